// ===== rtl/ldrs_pkg.sv =====
// ----------------------------------------------------------------------------
// ldrs_pkg
// Shared codes, record types and conversion constants for the LED dimmer
// channel with stairway timer.
// ----------------------------------------------------------------------------
`default_nettype none

package ldrs_pkg;

	// Command codes carried in the action field
	localparam logic [2:0] ACT_SWITCH  = 3'd0;
	localparam logic [2:0] ACT_PERCENT = 3'd1;
	localparam logic [2:0] ACT_STEP    = 3'd2;
	localparam logic [2:0] ACT_BLOCK   = 3'd3;
	localparam logic [2:0] ACT_TICK    = 3'd4;

	// Dimmer action held between transactions
	localparam logic [1:0] DIM_STANDBY = 2'd0;
	localparam logic [1:0] DIM_ON      = 2'd1;
	localparam logic [1:0] DIM_OFF     = 2'd2;
	localparam logic [1:0] DIM_DIMMING = 2'd3;

	// Stairway modes (any other nonzero code runs the two-stage mode)
	localparam logic [1:0] MODE_SIMPLE    = 2'd0;
	localparam logic [1:0] MODE_ONE_STAGE = 2'd1;

	// Report codes
	localparam logic [1:0] REPORT_NONE   = 2'd0;
	localparam logic [1:0] REPORT_SEND   = 2'd1;
	localparam logic [1:0] REPORT_UPDATE = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_MIN_LEVEL   = 3'd0;
	localparam logic [2:0] REG_MAX_LEVEL   = 3'd1;
	localparam logic [2:0] REG_UP_RATE     = 3'd2;
	localparam logic [2:0] REG_DOWN_RATE   = 3'd3;
	localparam logic [2:0] REG_STAIR_FIRST = 3'd4;
	localparam logic [2:0] REG_STAIR_MID   = 3'd5;
	localparam logic [2:0] REG_STAIR_SECOND = 3'd6;
	localparam logic [2:0] REG_DIM_MODE    = 3'd7;

	localparam logic [6:0]  PCT_FULL     = 7'd100;
	localparam logic [10:0] STEP_TENTHS  = 11'd50;
	localparam logic [9:0]  ON_MARGIN    = 10'd9;
	localparam logic [9:0]  REPORT_DELTA = 10'd10;

	// duty = floor(tenths * 65535 / 1000) = (tenths * DUTY_RECIP) >> DUTY_SHIFT
	localparam logic [26:0] DUTY_RECIP = 27'd68718429;
	localparam int          DUTY_SHIFT = 20;
	// percent = floor(tenths / 10) = (tenths * LEVEL_RECIP) >> LEVEL_SHIFT
	localparam logic [10:0] LEVEL_RECIP = 11'd1639;
	localparam int          LEVEL_SHIFT = 14;

	typedef struct packed {
		logic [6:0]  min_level;
		logic [6:0]  max_level;
		logic [15:0] up_rate;
		logic [15:0] down_rate;
		logic [31:0] stair_time_first;
		logic [6:0]  stair_level_mid;
		logic [31:0] stair_time_second;
		logic [1:0]  dim_mode;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [6:0]  command_value;
		logic [15:0] elapsed_ms;
	} item_t;

	typedef struct packed {
		logic [9:0] tenths;
		logic       is_on;
		logic [1:0] report;
	} step_res_t;

	// Saturate a percent at 100 and scale to tenths
	function automatic logic [9:0] pct_to_tenths(input logic [6:0] pct);
		logic [9:0] p;
		begin
			p = (pct > PCT_FULL) ? 10'(PCT_FULL) : 10'(pct);
			return (p << 3) + (p << 1);
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ldrs_step.sv =====
// ----------------------------------------------------------------------------
// ldrs_step
// Channel state and the combinational update for one transaction: commands,
// tick ramp with stairway timeouts, window clamp and report decision.
// ----------------------------------------------------------------------------
`default_nettype none

module ldrs_step (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ldrs_pkg::cfg_t    cfg,
	input  wire ldrs_pkg::item_t   item,
	input  wire logic              fire,
	output ldrs_pkg::step_res_t    res
);

	localparam logic [1:0] MOVE_NONE = 2'd0;
	localparam logic [1:0] MOVE_UP   = 2'd1;
	localparam logic [1:0] MOVE_DOWN = 2'd2;

	logic [1:0]  dim_action_q;
	logic [9:0]  cur_q;
	logic [9:0]  tgt_q;
	logic [31:0] timer_q;
	logic        blocked_q;

	logic [1:0]  dim_action_d;
	logic [9:0]  cur_d;
	logic [9:0]  tgt_d;
	logic [31:0] timer_d;
	logic        blocked_d;
	logic [1:0]  report_d;

	logic [9:0]  lo;
	logic [9:0]  hi;
	logic [9:0]  mid;
	logic [9:0]  on_floor;

	// tick datapath
	logic [1:0]  move_base;
	logic [1:0]  move_t;
	logic        stair_hit;
	logic [9:0]  stair_tgt;
	logic [9:0]  tgt_t;
	logic [31:0] up_step;
	logic [31:0] dn_step;
	logic [32:0] up_sum;
	logic [32:0] dn_lim;
	logic [9:0]  ramp_cur;
	logic        ramp_fin;
	logic [9:0]  tick_cur;
	logic        tick_fin;
	logic [31:0] timer_sum;
	logic [9:0]  diff;
	logic        tick_on;

	// command datapath
	logic [10:0] step_up;
	logic [9:0]  nv_up;
	logic [9:0]  nv_dn;
	logic [9:0]  nv;

	assign lo       = ldrs_pkg::pct_to_tenths(cfg.min_level);
	assign hi       = ldrs_pkg::pct_to_tenths(cfg.max_level);
	assign mid      = ldrs_pkg::pct_to_tenths(cfg.stair_level_mid);
	assign on_floor = lo + ldrs_pkg::ON_MARGIN;

	// Pick the ramp direction from the held action
	always_comb begin
		case (dim_action_q)
			ldrs_pkg::DIM_ON:      move_base = MOVE_UP;
			ldrs_pkg::DIM_OFF:     move_base = MOVE_DOWN;
			ldrs_pkg::DIM_DIMMING: move_base = (cur_q < tgt_q) ? MOVE_UP : MOVE_DOWN;
			default:               move_base = MOVE_NONE;
		endcase
	end

	// Move the target to a stairway level after timeouts while the target is above the floor
	always_comb begin
		stair_hit = 1'b0;
		stair_tgt = tgt_q;
		if (cfg.dim_mode != ldrs_pkg::MODE_SIMPLE && tgt_q > on_floor) begin
			if (cfg.dim_mode == ldrs_pkg::MODE_ONE_STAGE) begin
				if (timer_q > cfg.stair_time_first) begin
					stair_tgt = lo;
					stair_hit = 1'b1;
				end
			end else if (timer_q > cfg.stair_time_second) begin
				stair_tgt = lo;
				stair_hit = 1'b1;
			end else if (timer_q > cfg.stair_time_first) begin
				stair_tgt = mid;
				stair_hit = 1'b1;
			end
		end
		tgt_t  = stair_tgt;
		move_t = stair_hit ? ((cur_q < stair_tgt) ? MOVE_UP : MOVE_DOWN) : move_base;
	end

	// Ramp toward the target, saturating at it
	assign up_step = 32'(cfg.up_rate) * 32'(item.elapsed_ms);
	assign dn_step = 32'(cfg.down_rate) * 32'(item.elapsed_ms);
	assign up_sum  = 33'(up_step) + 33'(cur_q);
	assign dn_lim  = 33'(tgt_t) + 33'(dn_step);

	always_comb begin
		case (move_t)
			MOVE_UP: begin
				ramp_fin = (up_sum >= 33'(tgt_t));
				ramp_cur = ramp_fin ? tgt_t : up_sum[9:0];
			end
			MOVE_DOWN: begin
				ramp_cur = (33'(cur_q) >= dn_lim) ? (cur_q - dn_step[9:0]) : tgt_t;
				ramp_fin = (ramp_cur <= tgt_t);
			end
			default: begin
				ramp_cur = cur_q;
				ramp_fin = 1'b0;
			end
		endcase
	end

	// Clamp into the window; the minimum wins when the window is inverted
	always_comb begin
		tick_cur = ramp_cur;
		tick_fin = ramp_fin;
		if (ramp_cur <= lo) begin
			tick_cur = lo;
			tick_fin = 1'b1;
		end else if (ramp_cur >= hi) begin
			tick_cur = hi;
			tick_fin = 1'b1;
		end
	end

	assign timer_sum = timer_q + 32'(item.elapsed_ms);
	assign diff      = (tick_cur > cur_q) ? (tick_cur - cur_q) : (cur_q - tick_cur);
	assign tick_on   = (tick_cur > on_floor);

	// Step the target by five percent within the window
	assign step_up = 11'(tgt_q) + ldrs_pkg::STEP_TENTHS;
	assign nv_up   = (step_up >= 11'(hi)) ? hi : step_up[9:0];
	assign nv_dn   = (11'(tgt_q) >= 11'(lo) + ldrs_pkg::STEP_TENTHS) ?
		(tgt_q - ldrs_pkg::STEP_TENTHS[9:0]) : lo;
	assign nv      = (item.command_value != 7'd0) ? nv_up : nv_dn;

	// Next state for the transaction in hand
	always_comb begin
		dim_action_d = dim_action_q;
		cur_d        = cur_q;
		tgt_d        = tgt_q;
		timer_d      = timer_q;
		blocked_d    = blocked_q;
		report_d     = ldrs_pkg::REPORT_NONE;
		case (item.action)
			ldrs_pkg::ACT_SWITCH: begin
				if (!blocked_q) begin
					if (item.command_value != 7'd0) begin
						dim_action_d = ldrs_pkg::DIM_ON;
						tgt_d        = hi;
					end else begin
						dim_action_d = ldrs_pkg::DIM_OFF;
						tgt_d        = 10'd0;
					end
				end
			end
			ldrs_pkg::ACT_PERCENT: begin
				if (!blocked_q) begin
					dim_action_d = ldrs_pkg::DIM_DIMMING;
					tgt_d        = ldrs_pkg::pct_to_tenths(item.command_value);
				end
			end
			ldrs_pkg::ACT_STEP: begin
				if (!blocked_q && nv != tgt_q) begin
					dim_action_d = ldrs_pkg::DIM_DIMMING;
					tgt_d        = nv;
				end
			end
			ldrs_pkg::ACT_BLOCK: begin
				blocked_d = (item.command_value != 7'd0);
			end
			ldrs_pkg::ACT_TICK: begin
				cur_d   = tick_cur;
				tgt_d   = tgt_t;
				timer_d = timer_sum;
				if (tick_fin) begin
					dim_action_d = ldrs_pkg::DIM_STANDBY;
					report_d     = ldrs_pkg::REPORT_SEND;
					if (!tick_on) begin
						timer_d = 32'd0;
					end
				end else if (diff > ldrs_pkg::REPORT_DELTA) begin
					report_d = ldrs_pkg::REPORT_UPDATE;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.tenths = cur_d;
	assign res.is_on  = (cur_d > on_floor);
	assign res.report = report_d;

	// Commit the state when the transaction moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_action_q <= ldrs_pkg::DIM_OFF;
			cur_q        <= 10'd0;
			tgt_q        <= 10'd0;
			timer_q      <= 32'd0;
			blocked_q    <= 1'b0;
		end else if (fire) begin
			dim_action_q <= dim_action_d;
			cur_q        <= cur_d;
			tgt_q        <= tgt_d;
			timer_q      <= timer_d;
			blocked_q    <= blocked_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/led_dimmer_ramp_stairway_core.sv =====
// ----------------------------------------------------------------------------
// led_dimmer_ramp_stairway_core
// One LED dimmer channel: commands and millisecond ticks in, duty and status
// out, one result per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries action, command_value and
//   elapsed_ms. Each accepted transaction yields exactly one result on the
//   output channel (out_valid/out_stall): pwm_duty, level_percent, is_on and
//   report.
//   Stages: an input register, the state update stage and the duty output
//   register. Throughput: one transaction per cycle while out_stall is low;
//   the channel state is committed as each item leaves the update stage,
//   so back-to-back items see each other's effect.
//   Configuration: write cfg_data to register cfg_index while cfg_we is high;
//   write only while no transaction is in flight.
//   Reset: the channel starts off at level zero, unblocked, timer cleared;
//   registers take their documented defaults.
//   Stall: a stalled result holds; the empty stages in front still fill, and
//   in_stall rises only when every stage holds a transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module led_dimmer_ramp_stairway_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	// input channel
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [6:0]  command_value,
	input  wire logic [15:0] elapsed_ms,
	// output channel
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [15:0] pwm_duty,
	output      logic [6:0]  level_percent,
	output      logic        is_on,
	output      logic [1:0]  report
);

	ldrs_pkg::cfg_t      cfg_q;
	ldrs_pkg::item_t     item_s1;
	ldrs_pkg::step_res_t res;
	ldrs_pkg::step_res_t res_s2;

	logic        valid_s1;
	logic        valid_s2;
	logic        valid_s3;
	logic        en_s1;
	logic        en_s2;
	logic        en_s3;

	logic [36:0] duty_prod;
	logic [20:0] level_prod;

	logic [15:0] pwm_duty_s3;
	logic [6:0]  level_s3;
	logic        is_on_s3;
	logic [1:0]  report_s3;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_level         <= 7'd0;
			cfg_q.max_level         <= 7'd100;
			cfg_q.up_rate           <= 16'd100;
			cfg_q.down_rate         <= 16'd100;
			cfg_q.stair_time_first  <= 32'd0;
			cfg_q.stair_level_mid   <= 7'd0;
			cfg_q.stair_time_second <= 32'd0;
			cfg_q.dim_mode          <= 2'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				ldrs_pkg::REG_MIN_LEVEL:    cfg_q.min_level         <= cfg_data[6:0];
				ldrs_pkg::REG_MAX_LEVEL:    cfg_q.max_level         <= cfg_data[6:0];
				ldrs_pkg::REG_UP_RATE:      cfg_q.up_rate           <= cfg_data[15:0];
				ldrs_pkg::REG_DOWN_RATE:    cfg_q.down_rate         <= cfg_data[15:0];
				ldrs_pkg::REG_STAIR_FIRST:  cfg_q.stair_time_first  <= cfg_data;
				ldrs_pkg::REG_STAIR_MID:    cfg_q.stair_level_mid   <= cfg_data[6:0];
				ldrs_pkg::REG_STAIR_SECOND: cfg_q.stair_time_second <= cfg_data;
				ldrs_pkg::REG_DIM_MODE:     cfg_q.dim_mode          <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// Advance a stage when its slot is empty or its contents move on
	assign en_s3    = !valid_s3 || !out_stall;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Capture the incoming transaction
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			item_s1.action        <= action;
			item_s1.command_value <= command_value;
			item_s1.elapsed_ms    <= elapsed_ms;
		end
	end

	ldrs_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item_s1),
		.fire   (valid_s1 && en_s2),
		.res    (res)
	);

	// Hold the updated level and report
	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			res_s2 <= res;
		end
	end

	// Scale tenths to duty and percent by reciprocal multiplication
	assign duty_prod  = 37'(res_s2.tenths) * 37'(ldrs_pkg::DUTY_RECIP);
	assign level_prod = 21'(res_s2.tenths) * 21'(ldrs_pkg::LEVEL_RECIP);

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			pwm_duty_s3 <= duty_prod[ldrs_pkg::DUTY_SHIFT +: 16];
			level_s3    <= level_prod[ldrs_pkg::LEVEL_SHIFT +: 7];
			is_on_s3    <= res_s2.is_on;
			report_s3   <= res_s2.report;
		end
	end

	assign out_valid     = valid_s3;
	assign pwm_duty      = pwm_duty_s3;
	assign level_percent = level_s3;
	assign is_on         = is_on_s3;
	assign report        = report_s3;

endmodule

`default_nettype wire

// ===== bench/ldrs_dimmer_checker.sv =====
// ----------------------------------------------------------------------------
// ldrs_dimmer_checker
// Watches the register port and both channels of the dimmer core. Keeps its
// own copy of the channel state and registers, works out the status for each
// accepted command or tick, and compares every delivered result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ldrs_dimmer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  action,
	input  logic [6:0]  command_value,
	input  logic [15:0] elapsed_ms,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] pwm_duty,
	input  logic [6:0]  level_percent,
	input  logic        is_on,
	input  logic [1:0]  report,
	output int          errors,
	output int          outstanding
);

	localparam int unsigned TENTHS_PER_PCT = 10;
	localparam int unsigned NUDGE_TENTHS   = 50;
	localparam int unsigned DUTY_MAX       = 65535;
	localparam int unsigned SCALE_TENTHS   = 1000;

	typedef struct packed {
		logic [15:0] duty;
		logic [6:0]  percent;
		logic        lit;
		logic [1:0]  rpt;
	} status_t;

	typedef enum logic [1:0] {RAMP_NONE, RAMP_UP, RAMP_DOWN} ramp_t;

	ldrs_pkg::cfg_t regs;
	logic [1:0]  chan_action;
	logic [9:0]  level_tenths;
	logic [9:0]  goal_tenths;
	logic [31:0] lit_ms;
	logic        locked;
	status_t     pending_status[$];

	// Percent registers and commands saturate at full scale
	function automatic logic [6:0] sat_pct(logic [6:0] p);
		return (p > ldrs_pkg::PCT_FULL) ? ldrs_pkg::PCT_FULL : p;
	endfunction

	function automatic logic [9:0] pct_tenths(logic [6:0] p);
		return 10'(sat_pct(p) * TENTHS_PER_PCT);
	endfunction

	// Ramp, stairway and window clamp for one tick; returns the report code
	function automatic logic [1:0] ramp_on_tick(logic [15:0] ms);
		logic [9:0]  floor_t, ceil_t, prev, goal, stage;
		logic [63:0] cur, sum, drop;
		logic [9:0]  diff;
		ramp_t       dir;
		logic        done, hit, lit;
		floor_t = pct_tenths(regs.min_level);
		ceil_t  = pct_tenths(regs.max_level);
		prev    = level_tenths;
		cur     = 64'(level_tenths);
		goal    = goal_tenths;
		stage   = goal;
		done    = 1'b0;
		hit     = 1'b0;
		case (chan_action)
			ldrs_pkg::DIM_ON:      dir = RAMP_UP;
			ldrs_pkg::DIM_OFF:     dir = RAMP_DOWN;
			ldrs_pkg::DIM_DIMMING: dir = (cur < 64'(goal)) ? RAMP_UP : RAMP_DOWN;
			default:               dir = RAMP_NONE;
		endcase

		// stairway: set the goal to a stairway level once the lit time passes a threshold
		if (regs.dim_mode != ldrs_pkg::MODE_SIMPLE
				&& goal / TENTHS_PER_PCT > sat_pct(regs.min_level)) begin
			if (regs.dim_mode == ldrs_pkg::MODE_ONE_STAGE) begin
				if (lit_ms > regs.stair_time_first) begin
					stage = floor_t;
					hit = 1'b1;
				end
			end else if (lit_ms > regs.stair_time_second) begin
				stage = floor_t;
				hit = 1'b1;
			end else if (lit_ms > regs.stair_time_first) begin
				stage = pct_tenths(regs.stair_level_mid);
				hit = 1'b1;
			end
			if (hit) begin
				dir = (cur < 64'(stage)) ? RAMP_UP : RAMP_DOWN;
				goal = stage;
			end
		end

		// move toward the goal and saturate there
		if (dir == RAMP_UP) begin
			sum = cur + 64'(regs.up_rate) * 64'(ms);
			cur = (sum >= 64'(goal)) ? 64'(goal) : sum;
			if (cur >= 64'(goal)) done = 1'b1;
		end else if (dir == RAMP_DOWN) begin
			drop = 64'(regs.down_rate) * 64'(ms);
			cur = (cur >= 64'(goal) + drop) ? cur - drop : 64'(goal);
			if (cur <= 64'(goal)) done = 1'b1;
		end

		// clamp into the window; the floor wins an inverted window
		if (cur <= 64'(floor_t)) begin
			cur = 64'(floor_t);
			done = 1'b1;
		end else if (cur >= 64'(ceil_t)) begin
			cur = 64'(ceil_t);
			done = 1'b1;
		end

		lit_ms       = lit_ms + 32'(ms);
		level_tenths = cur[9:0];
		goal_tenths  = goal;
		diff = (level_tenths > prev) ? level_tenths - prev : prev - level_tenths;
		lit  = (level_tenths / TENTHS_PER_PCT) > sat_pct(regs.min_level);
		if (done) begin
			chan_action = ldrs_pkg::DIM_STANDBY;
			if (!lit) lit_ms = '0;
			return ldrs_pkg::REPORT_SEND;
		end
		if (diff > TENTHS_PER_PCT) return ldrs_pkg::REPORT_UPDATE;
		return ldrs_pkg::REPORT_NONE;
	endfunction

	// Apply one transaction to the channel state and build its status
	function automatic status_t advance_dimmer(logic [2:0] act, logic [6:0] val,
			logic [15:0] ms);
		status_t     res;
		logic [1:0]  rpt;
		logic [11:0] cur_goal, next_goal, floor_t, ceil_t;
		rpt     = ldrs_pkg::REPORT_NONE;
		floor_t = 12'(pct_tenths(regs.min_level));
		ceil_t  = 12'(pct_tenths(regs.max_level));
		case (act)
			ldrs_pkg::ACT_SWITCH: if (!locked) begin
				if (val != '0) begin
					chan_action = ldrs_pkg::DIM_ON;
					goal_tenths = ceil_t[9:0];
				end else begin
					chan_action = ldrs_pkg::DIM_OFF;
					goal_tenths = '0;
				end
			end
			ldrs_pkg::ACT_PERCENT: if (!locked) begin
				chan_action = ldrs_pkg::DIM_DIMMING;
				goal_tenths = pct_tenths(val);
			end
			ldrs_pkg::ACT_STEP: if (!locked) begin
				cur_goal = 12'(goal_tenths);
				if (val != '0)
					next_goal = (cur_goal + NUDGE_TENTHS >= ceil_t) ? ceil_t
						: cur_goal + 12'(NUDGE_TENTHS);
				else
					next_goal = (cur_goal >= floor_t + NUDGE_TENTHS)
						? cur_goal - 12'(NUDGE_TENTHS) : floor_t;
				if (next_goal != cur_goal) begin
					chan_action = ldrs_pkg::DIM_DIMMING;
					goal_tenths = next_goal[9:0];
				end
			end
			ldrs_pkg::ACT_BLOCK: locked = (val != '0);
			ldrs_pkg::ACT_TICK:  rpt = ramp_on_tick(ms);
			default: ;
		endcase
		res.duty    = 16'((32'(level_tenths) * DUTY_MAX) / SCALE_TENTHS);
		res.percent = 7'(level_tenths / TENTHS_PER_PCT);
		res.lit     = (level_tenths / TENTHS_PER_PCT) > sat_pct(regs.min_level);
		res.rpt     = rpt;
		return res;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Track registers, retire results, then predict newly accepted items
	always @(posedge clk or negedge arst_n) begin
		status_t want;
		if (!arst_n) begin
			regs           = '0;
			regs.max_level = 7'd100;
			regs.up_rate   = 16'd100;
			regs.down_rate = 16'd100;
			chan_action    = ldrs_pkg::DIM_OFF;
			level_tenths   = '0;
			goal_tenths    = '0;
			lit_ms         = '0;
			locked         = 1'b0;
			pending_status.delete();
			errors         = 0;
			outstanding    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ldrs_pkg::REG_MIN_LEVEL:    regs.min_level         = cfg_data[6:0];
					ldrs_pkg::REG_MAX_LEVEL:    regs.max_level         = cfg_data[6:0];
					ldrs_pkg::REG_UP_RATE:      regs.up_rate           = cfg_data[15:0];
					ldrs_pkg::REG_DOWN_RATE:    regs.down_rate         = cfg_data[15:0];
					ldrs_pkg::REG_STAIR_FIRST:  regs.stair_time_first  = cfg_data;
					ldrs_pkg::REG_STAIR_MID:    regs.stair_level_mid   = cfg_data[6:0];
					ldrs_pkg::REG_STAIR_SECOND: regs.stair_time_second = cfg_data;
					ldrs_pkg::REG_DIM_MODE:     regs.dim_mode          = cfg_data[1:0];
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				if (pending_status.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual duty %0d level %0d on %0b report %0d",
						$time, pwm_duty, level_percent, is_on, report);
				end else begin
					want = pending_status.pop_front();
					check_field("pwm_duty", want.duty, pwm_duty);
					check_field("level_percent", want.percent, level_percent);
					check_field("is_on", want.lit, is_on);
					check_field("report", want.rpt, report);
				end
			end

			if (in_valid && !in_stall)
				pending_status.push_back(advance_dimmer(action, command_value, elapsed_ms));

			outstanding = pending_status.size();
		end
	end

endmodule

// ===== bench/led_dimmer_ramp_stairway_core_tb.sv =====
// ----------------------------------------------------------------------------
// led_dimmer_ramp_stairway_core_tb
// Drives commands and ticks into the dimmer core through a short directed
// opening and several register settings with random traffic, bursty input
// and random output stalls, one long output hold-off included. The checker
// beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module led_dimmer_ramp_stairway_core_tb;

	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 64;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [1:0] MODE_TWO_STAGE     = 2'd2;
	localparam logic [1:0] MODE_TWO_STAGE_ALT = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = ldrs_pkg::REG_MIN_LEVEL;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  action = ldrs_pkg::ACT_SWITCH;
	logic [6:0]  command_value = '0;
	logic [15:0] elapsed_ms = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] pwm_duty;
	logic [6:0]  level_percent;
	logic        is_on;
	logic [1:0]  report;
	int          errors;
	int          outstanding;
	int          stall_pct = 0;
	int          hold_requests = 0;
	int          idle_cycles = 0;

	always #5 clk = ~clk;

	led_dimmer_ramp_stairway_core u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .command_value(command_value), .elapsed_ms(elapsed_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.pwm_duty(pwm_duty), .level_percent(level_percent), .is_on(is_on), .report(report)
	);

	ldrs_dimmer_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .command_value(command_value), .elapsed_ms(elapsed_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.pwm_duty(pwm_duty), .level_percent(level_percent), .is_on(is_on), .report(report),
		.errors(errors), .outstanding(outstanding)
	);

	// Receiver: random stalls, or a long hold-off when one is requested
	initial begin : receiver
		int served;
		served = 0;
		forever begin
			@(posedge clk);
			if (hold_requests > served) begin
				served++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offer one transaction and hold it until accepted
	task automatic send_item(logic [2:0] act, logic [6:0] val, logic [15:0] ms);
		in_valid      <= 1'b1;
		action        <= act;
		command_value <= val;
		elapsed_ms    <= ms;
		do @(posedge clk); while (in_stall);
	endtask

	// Mostly ticks and commands; a few blocks and unused action codes
	task automatic send_random();
		logic [2:0]  act;
		logic [6:0]  val;
		logic [15:0] ms;
		int          pick;
		pick = $urandom_range(0, 99);
		val  = 7'($urandom_range(0, 127));
		ms   = 16'($urandom_range(0, 65535));
		if (pick < 45) begin
			act = ldrs_pkg::ACT_TICK;
			case ($urandom_range(0, 9))
				7, 8:    ms = 16'($urandom_range(0, 300));
				9:       ;
				default: ms = 16'($urandom_range(0, 12));
			endcase
		end else if (pick < 57) begin
			act = ldrs_pkg::ACT_SWITCH;
			if ($urandom_range(0, 3) != 0) val = 7'($urandom_range(0, 1));
		end else if (pick < 72) begin
			act = ldrs_pkg::ACT_PERCENT;
			if ($urandom_range(0, 5) != 0) val = 7'($urandom_range(0, 100));
		end else if (pick < 89) begin
			act = ldrs_pkg::ACT_STEP;
			if ($urandom_range(0, 3) != 0) val = 7'($urandom_range(0, 1));
		end else if (pick < 96) begin
			act = ldrs_pkg::ACT_BLOCK;
			if ($urandom_range(0, 3) != 0) val = '0;
		end else begin
			act = ldrs_pkg::ACT_TICK + 3'($urandom_range(1, 3));
		end
		send_item(act, val, ms);
	endtask

	// Random traffic in bursts with random gaps
	task automatic run_traffic(int count, int pct, int max_gap);
		int sent, burst, gap;
		stall_pct <= pct;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && sent < count; k++) begin
				send_random();
				sent++;
			end
			gap = $urandom_range(0, max_gap);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop offering and wait until every result has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic apply_settings(logic [6:0] lo, logic [6:0] hi, logic [15:0] up,
			logic [15:0] down, logic [31:0] first, logic [6:0] mid,
			logic [31:0] second, logic [1:0] mode);
		write_reg(ldrs_pkg::REG_MIN_LEVEL, 32'(lo));
		write_reg(ldrs_pkg::REG_MAX_LEVEL, 32'(hi));
		write_reg(ldrs_pkg::REG_UP_RATE, 32'(up));
		write_reg(ldrs_pkg::REG_DOWN_RATE, 32'(down));
		write_reg(ldrs_pkg::REG_STAIR_FIRST, first);
		write_reg(ldrs_pkg::REG_STAIR_MID, 32'(mid));
		write_reg(ldrs_pkg::REG_STAIR_SECOND, second);
		write_reg(ldrs_pkg::REG_DIM_MODE, 32'(mode));
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [31:0] first_ms;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// opening under reset settings, no stalls
		send_item(ldrs_pkg::ACT_TICK, 7'd0, 16'd0);
		send_item(ldrs_pkg::ACT_SWITCH, 7'd1, 16'd0);
		send_item(ldrs_pkg::ACT_TICK, 7'd0, 16'd5);
		send_item(ldrs_pkg::ACT_TICK, 7'd0, 16'hFFFF);
		send_item(ldrs_pkg::ACT_STEP, 7'd1, 16'd0);
		send_item(ldrs_pkg::ACT_STEP, 7'd0, 16'd0);
		send_item(ldrs_pkg::ACT_STEP, 7'd127, 16'd0);
		send_item(ldrs_pkg::ACT_TICK, 7'd0, 16'd1);
		send_item(ldrs_pkg::ACT_PERCENT, 7'd127, 16'd0);
		send_item(ldrs_pkg::ACT_TICK, 7'd127, 16'hFFFF);
		send_item(ldrs_pkg::ACT_PERCENT, 7'd0, 16'd0);
		send_item(ldrs_pkg::ACT_TICK, 7'd0, 16'd2);
		send_item(ldrs_pkg::ACT_BLOCK, 7'd1, 16'd0);
		send_item(ldrs_pkg::ACT_SWITCH, 7'd0, 16'd0);
		send_item(ldrs_pkg::ACT_PERCENT, 7'd50, 16'd0);
		send_item(ldrs_pkg::ACT_STEP, 7'd1, 16'd0);
		send_item(ldrs_pkg::ACT_BLOCK, 7'd127, 16'd0);
		send_item(ldrs_pkg::ACT_BLOCK, 7'd0, 16'd0);
		send_item(ldrs_pkg::ACT_TICK + 3'd1, 7'd127, 16'hFFFF);
		send_item(ldrs_pkg::ACT_TICK + 3'd2, 7'd85, 16'h5555);
		send_item(ldrs_pkg::ACT_TICK + 3'd3, 7'd42, 16'hAAAA);
		send_item(ldrs_pkg::ACT_SWITCH, 7'd127, 16'd0);
		send_item(ldrs_pkg::ACT_TICK, 7'd0, 16'hFFFF);
		send_item(ldrs_pkg::ACT_SWITCH, 7'd0, 16'd0);
		send_item(ldrs_pkg::ACT_TICK, 7'd0, 16'hFFFF);
		settle();

		// slowest ramps, plain dimmer
		apply_settings(7'd0, 7'd100, 16'd1, 16'd1, 32'd0, 7'd0, 32'd0,
			ldrs_pkg::MODE_SIMPLE);
		run_traffic(120, 20, 4);
		settle();

		// fastest ramps, one-stage stairway; fill the core under a long hold
		apply_settings(7'd20, 7'd80, 16'hFFFF, 16'hFFFF, 32'd100, 7'd50, 32'd300,
			ldrs_pkg::MODE_ONE_STAGE);
		hold_requests <= hold_requests + 1;
		run_traffic(40, 0, 0);
		run_traffic(100, 40, 6);
		settle();

		// inverted window, frozen ramps, saturated percents, mode three
		apply_settings(7'd127, 7'd0, 16'd0, 16'd0, 32'hFFFF_FFFF, 7'd127, 32'hFFFF_FFFF,
			MODE_TWO_STAGE_ALT);
		run_traffic(100, 10, 2);
		settle();

		// two-stage stairway with short thresholds; pause midway until drained
		first_ms = 32'($urandom_range(0, 150));
		apply_settings(7'd10, 7'd90, 16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)),
			first_ms, 7'($urandom_range(0, 127)), first_ms + 32'($urandom_range(0, 400)),
			MODE_TWO_STAGE);
		run_traffic(75, 30, 5);
		settle();
		run_traffic(75, 0, 3);
		settle();

		// random settings
		repeat (2) begin
			apply_settings(7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
					: $urandom_range(0, 60)),
				7'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), 32'($urandom_range(0, 2000)),
				7'($urandom_range(0, 127)), 32'($urandom_range(0, 4000)),
				2'($urandom_range(0, 3)));
			run_traffic(100, $urandom_range(0, 60), $urandom_range(1, 8));
			settle();
		end

		if (errors == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
